// ===== src/hsv2rgb_pkg.sv =====
// shared constants for the hsv to rgb pixel converter
package hsv2rgb_pkg;

    localparam int HUE_W               = 18;
    localparam int LEVEL_W             = 12;
    localparam int CHAN_W              = 8;
    localparam int SECTOR_W            = 3;
    localparam int HUE_FRAC_BITS_DEF   = 6;
    localparam int LEVEL_FRAC_BITS_DEF = 10;

    // 60 degree sectors of the hue circle, magenta to red is the remaining one
    localparam logic [SECTOR_W-1:0] SEC_RED_YEL = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_YEL_GRN = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_GRN_CYN = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYN_BLU = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLU_MAG = 3'd4;

endpackage

// ===== src/hsv2rgb_pipe_ctrl.sv =====
// valid and stall control for an elastic register pipeline
module hsv2rgb_pipe_ctrl #(
    parameter int STAGES = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_stall,
    output logic [STAGES-1:0] o_en,
    output logic [STAGES-1:0] o_valid
);

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] n_valid;
    logic [STAGES-1:0] rdy;

    always_comb begin
        rdy[STAGES-1] = !i_stall || !r_valid[STAGES-1];
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (!rdy[k]) begin
                n_valid[k] = r_valid[k];
            end else if (k == 0) begin
                n_valid[k] = i_valid;
            end else begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !rdy[0];
    assign o_en    = rdy;
    assign o_valid = r_valid;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> &r_valid)
        else $error("upstream stalled while a stage is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_valid[0])
        else $error("accepted word missing from first stage");

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[STAGES-1] && i_stall |=> r_valid[STAGES-1])
        else $error("stalled output word dropped");

endmodule

// ===== src/hsv2rgb_hue_wrap.sv =====
// level clamp, hue wrap and split of the hue into sector and remainder
module hsv2rgb_hue_wrap #(
    parameter int HUE_FRAC_BITS   = hsv2rgb_pkg::HUE_FRAC_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = hsv2rgb_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic signed [hsv2rgb_pkg::HUE_W-1:0]      i_hue_angle,
    input  logic signed [hsv2rgb_pkg::LEVEL_W-1:0]    i_saturation,
    input  logic signed [hsv2rgb_pkg::LEVEL_W-1:0]    i_brightness,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic [hsv2rgb_pkg::SECTOR_W-1:0]          o_sector,
    output logic [$clog2(60 << HUE_FRAC_BITS)-1:0]    o_rem,
    output logic [LEVEL_FRAC_BITS:0]                  o_sat,
    output logic [LEVEL_FRAC_BITS:0]                  o_val
);

    localparam int STAGES = 5;
    localparam int FT     = 360 << HUE_FRAC_BITS;
    localparam int D      = 60 << HUE_FRAC_BITS;
    localparam int HALF   = 2 ** (hsv2rgb_pkg::HUE_W - 1);
    localparam int OFF    = ((HALF + FT - 1) / FT) * FT;
    localparam int UW     = $clog2(OFF + HALF);
    localparam int M      = (2 ** UW) / FT;
    localparam int MW     = $clog2(M + 1);
    localparam int WW0    = ($clog2(2 * FT) < UW) ? $clog2(2 * FT) : UW;
    localparam int WW     = $clog2(FT);
    localparam int RW     = $clog2(D);
    localparam int LVW    = LEVEL_FRAC_BITS + 1;
    localparam int ONE    = 2 ** LEVEL_FRAC_BITS;
    localparam int CW     = (hsv2rgb_pkg::LEVEL_W - 1 > LVW) ? hsv2rgb_pkg::LEVEL_W - 1 : LVW;

    localparam logic [MW-1:0] M_C  = MW'(M);
    localparam logic [UW-1:0] FT_U = UW'(FT);

    function automatic logic [LVW-1:0] clamp_level(
        input logic signed [hsv2rgb_pkg::LEVEL_W-1:0] x
    );
        logic [CW-1:0] mag;
        mag = CW'(x[hsv2rgb_pkg::LEVEL_W-2:0]);
        if (x[hsv2rgb_pkg::LEVEL_W-1]) begin
            clamp_level = '0;
        end else if (mag > CW'(ONE)) begin
            clamp_level = LVW'(ONE);
        end else begin
            clamp_level = LVW'(mag);
        end
    endfunction

    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vld;

    hsv2rgb_pipe_ctrl #(
        .STAGES (STAGES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_en    (en),
        .o_valid (vld)
    );

    logic [LVW-1:0] r_sat [STAGES];
    logic [LVW-1:0] r_val [STAGES];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_sat[0] <= clamp_level(i_saturation);
            r_val[0] <= clamp_level(i_brightness);
        end
        for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
                r_sat[k] <= r_sat[k-1];
                r_val[k] <= r_val[k-1];
            end
        end
    end

    // offset hue, always nonnegative and a multiple of a full turn above the input
    logic [UW-1:0] r1_u;
    logic [UW-1:0] n1_u;

    assign n1_u = UW'(int'(i_hue_angle) + OFF);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_u <= n1_u;
        end
    end

    // quotient estimate by reciprocal, low by at most one
    logic [UW+MW-1:0] n2_prod;
    logic [UW-1:0]    r2_u;
    logic [MW-1:0]    r2_qe;

    assign n2_prod = {{MW{1'b0}}, r1_u} * {{UW{1'b0}}, M_C};

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_u  <= r1_u;
            r2_qe <= n2_prod[UW +: MW];
        end
    end

    logic [UW+MW-1:0] n3_qft;
    logic [UW-1:0]    n3_diff;
    logic [WW0-1:0]   r3_w0;

    assign n3_qft  = {{UW{1'b0}}, r2_qe} * {{MW{1'b0}}, FT_U};
    assign n3_diff = r2_u - n3_qft[UW-1:0];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_w0 <= n3_diff[WW0-1:0];
        end
    end

    logic [WW0-1:0] n4_sub;
    logic [WW-1:0]  r4_w;

    assign n4_sub = r3_w0 - WW0'(FT);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_w <= (r3_w0 >= WW0'(FT)) ? n4_sub[WW-1:0] : r3_w0[WW-1:0];
        end
    end

    logic [hsv2rgb_pkg::SECTOR_W-1:0] n5_sec;
    logic [WW-1:0]                    n5_base;
    logic [WW-1:0]                    n5_rem;
    logic [hsv2rgb_pkg::SECTOR_W-1:0] r5_sec;
    logic [RW-1:0]                    r5_rem;

    always_comb begin
        n5_sec  = '0;
        n5_base = '0;
        for (int k = 1; k < 6; k++) begin
            if (r4_w >= WW'(k * D)) begin
                n5_sec  = hsv2rgb_pkg::SECTOR_W'(k);
                n5_base = WW'(k * D);
            end
        end
    end

    assign n5_rem = r4_w - n5_base;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_sec <= n5_sec;
            r5_rem <= n5_rem[RW-1:0];
        end
    end

    assign o_valid  = vld[STAGES-1];
    assign o_sector = r5_sec;
    assign o_rem    = r5_rem;
    assign o_sat    = r_sat[STAGES-1];
    assign o_val    = r_val[STAGES-1];

endmodule

// ===== src/hsv2rgb_chan_calc.sv =====
// p, q, t and v products, scaling to 8 bits and channel selection by sector
module hsv2rgb_chan_calc #(
    parameter int HUE_FRAC_BITS   = hsv2rgb_pkg::HUE_FRAC_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = hsv2rgb_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [hsv2rgb_pkg::SECTOR_W-1:0]       i_sector,
    input  logic [$clog2(60 << HUE_FRAC_BITS)-1:0] i_rem,
    input  logic [LEVEL_FRAC_BITS:0]               i_sat,
    input  logic [LEVEL_FRAC_BITS:0]               i_val,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]         o_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]         o_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]         o_blue
);

    localparam int     STAGES = 3;
    localparam int     CH     = hsv2rgb_pkg::CHAN_W;
    localparam int     SW     = hsv2rgb_pkg::SECTOR_W;
    localparam int     D      = 60 << HUE_FRAC_BITS;
    localparam int     ONE    = 2 ** LEVEL_FRAC_BITS;
    localparam longint ONED   = longint'(ONE) * longint'(D);
    localparam int     LVW    = LEVEL_FRAC_BITS + 1;
    localparam int     RW     = $clog2(D);
    localparam int     DW     = $clog2(D + 1);
    localparam int     NW     = $clog2(ONED + 1);
    localparam int     PW     = LVW + NW;
    localparam int     SHQ    = 2 * LEVEL_FRAC_BITS + HUE_FRAC_BITS + 2;

    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vld;

    hsv2rgb_pipe_ctrl #(
        .STAGES (STAGES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_en    (en),
        .o_valid (vld)
    );

    // s*f and s*(1-f) terms
    logic [DW-1:0]     n1_drem;
    logic [LVW+RW-1:0] n1_sr;
    logic [LVW+DW-1:0] n1_sd;
    logic [NW-1:0]     r1_nq;
    logic [NW-1:0]     r1_nt;
    logic [LVW-1:0]    r1_np;
    logic [LVW-1:0]    r1_val;
    logic [SW-1:0]     r1_sec;

    assign n1_drem = DW'(D) - DW'(i_rem);
    assign n1_sr   = {{RW{1'b0}}, i_sat} * {{LVW{1'b0}}, i_rem};
    assign n1_sd   = {{DW{1'b0}}, i_sat} * {{LVW{1'b0}}, n1_drem};

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_nq  <= NW'(ONED) - NW'(n1_sr);
            r1_nt  <= NW'(ONED) - NW'(n1_sd);
            r1_np  <= LVW'(ONE) - i_sat;
            r1_val <= i_val;
            r1_sec <= i_sector;
        end
    end

    logic [PW-1:0]    r2_pq;
    logic [PW-1:0]    r2_pt;
    logic [2*LVW-1:0] r2_pp;
    logic [LVW-1:0]   r2_val;
    logic [SW-1:0]    r2_sec;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_pq  <= {{NW{1'b0}}, r1_val} * {{LVW{1'b0}}, r1_nq};
            r2_pt  <= {{NW{1'b0}}, r1_val} * {{LVW{1'b0}}, r1_nt};
            r2_pp  <= {{LVW{1'b0}}, r1_val} * {{LVW{1'b0}}, r1_np};
            r2_val <= r1_val;
            r2_sec <= r1_sec;
        end
    end

    // 255 / (15 * 2^k) reduces to 17 / 2^k for q and t
    logic [PW+4:0]    n3_q17;
    logic [PW+4:0]    n3_t17;
    logic [2*LVW+7:0] n3_p255;
    logic [LVW+7:0]   n3_v255;
    logic [CH-1:0]    cq;
    logic [CH-1:0]    ct;
    logic [CH-1:0]    cp;
    logic [CH-1:0]    cv;
    logic [CH-1:0]    n3_red;
    logic [CH-1:0]    n3_green;
    logic [CH-1:0]    n3_blue;
    logic [CH-1:0]    r3_red;
    logic [CH-1:0]    r3_green;
    logic [CH-1:0]    r3_blue;

    assign n3_q17  = (PW+5)'({r2_pq, 4'b0000}) + (PW+5)'(r2_pq);
    assign n3_t17  = (PW+5)'({r2_pt, 4'b0000}) + (PW+5)'(r2_pt);
    assign n3_p255 = {r2_pp, 8'b0000_0000} - (2*LVW+8)'(r2_pp);
    assign n3_v255 = {r2_val, 8'b0000_0000} - (LVW+8)'(r2_val);

    assign cq = n3_q17[SHQ +: CH];
    assign ct = n3_t17[SHQ +: CH];
    assign cp = n3_p255[2*LEVEL_FRAC_BITS +: CH];
    assign cv = n3_v255[LEVEL_FRAC_BITS +: CH];

    always_comb begin
        case (r2_sec)
            hsv2rgb_pkg::SEC_RED_YEL: begin
                n3_red = cv; n3_green = ct; n3_blue = cp;
            end
            hsv2rgb_pkg::SEC_YEL_GRN: begin
                n3_red = cq; n3_green = cv; n3_blue = cp;
            end
            hsv2rgb_pkg::SEC_GRN_CYN: begin
                n3_red = cp; n3_green = cv; n3_blue = ct;
            end
            hsv2rgb_pkg::SEC_CYN_BLU: begin
                n3_red = cp; n3_green = cq; n3_blue = cv;
            end
            hsv2rgb_pkg::SEC_BLU_MAG: begin
                n3_red = ct; n3_green = cp; n3_blue = cv;
            end
            default: begin
                n3_red = cv; n3_green = cp; n3_blue = cq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_red   <= n3_red;
            r3_green <= n3_green;
            r3_blue  <= n3_blue;
        end
    end

    assign o_valid = vld[STAGES-1];
    assign o_red   = r3_red;
    assign o_green = r3_green;
    assign o_blue  = r3_blue;

endmodule

// ===== src/hsv_to_rgb_pixel_converter_unit.sv =====
// top level of the hsv to rgb pixel converter
// throughput: one word per cycle unless stalled, five hue stages then three channel stages
// empty stages fill while the output is stalled, stall reaches the input only when all are full
// reset: synchronous, active low, clears the stage valid bits only
module hsv_to_rgb_pixel_converter_unit #(
    parameter int HUE_FRAC_BITS   = hsv2rgb_pkg::HUE_FRAC_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = hsv2rgb_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [hsv2rgb_pkg::HUE_W-1:0]   i_hue_angle,
    input  logic signed [hsv2rgb_pkg::LEVEL_W-1:0] i_saturation,
    input  logic signed [hsv2rgb_pkg::LEVEL_W-1:0] i_brightness,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]         o_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]         o_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]         o_blue
);

    logic                                   hue_valid;
    logic                                   chan_stall;
    logic [hsv2rgb_pkg::SECTOR_W-1:0]       hue_sector;
    logic [$clog2(60 << HUE_FRAC_BITS)-1:0] hue_rem;
    logic [LEVEL_FRAC_BITS:0]               hue_sat;
    logic [LEVEL_FRAC_BITS:0]               hue_val;

    hsv2rgb_hue_wrap #(
        .HUE_FRAC_BITS   (HUE_FRAC_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_hue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue_angle  (i_hue_angle),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (hue_valid),
        .i_stall      (chan_stall),
        .o_sector     (hue_sector),
        .o_rem        (hue_rem),
        .o_sat        (hue_sat),
        .o_val        (hue_val)
    );

    hsv2rgb_chan_calc #(
        .HUE_FRAC_BITS   (HUE_FRAC_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_chan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (hue_valid),
        .o_stall  (chan_stall),
        .i_sector (hue_sector),
        .i_rem    (hue_rem),
        .i_sat    (hue_sat),
        .i_val    (hue_val),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

endmodule

// ===== sim/tb_hsv_to_rgb_pixel_converter_unit.sv =====
// self-checking testbench for the hsv to rgb pixel converter
module tb_hsv_to_rgb_pixel_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY      = 8;
    localparam int RANDOM_WORDS = 850;
    localparam int HOLD_CYCLES  = 64;
    localparam int QUIET_LIMIT  = 3000;

    typedef struct packed {
        logic [hsv2rgb_pkg::CHAN_W-1:0] red;
        logic [hsv2rgb_pkg::CHAN_W-1:0] green;
        logic [hsv2rgb_pkg::CHAN_W-1:0] blue;
    } t_rgb_pixel;

    typedef struct packed {
        logic signed [hsv2rgb_pkg::HUE_W-1:0]   hue;
        logic signed [hsv2rgb_pkg::LEVEL_W-1:0] sat;
        logic signed [hsv2rgb_pkg::LEVEL_W-1:0] bri;
    } t_hsv_pixel;

    class t_rgb_scoreboard;
        t_rgb_pixel expected_rgb[$];
        int         fail_count;

        function longint clamp_level(longint x, longint one);
            if (x < 0) begin
                return 0;
            end
            if (x > one) begin
                return one;
            end
            return x;
        endfunction

        function t_rgb_pixel convert_hsv(t_hsv_pixel px);
            longint one, span, turn, h, s, v, cv, cp, cq, ct, sector, rem;
            t_rgb_pixel res;
            one  = longint'(1) << hsv2rgb_pkg::LEVEL_FRAC_BITS_DEF;
            span = longint'(60) << hsv2rgb_pkg::HUE_FRAC_BITS_DEF;
            turn = longint'(360) << hsv2rgb_pkg::HUE_FRAC_BITS_DEF;
            h    = px.hue;
            s    = clamp_level(longint'(px.sat), one);
            v    = clamp_level(longint'(px.bri), one);
            h    = h % turn;
            if (h < 0) begin
                h = h + turn;
            end
            cv = (255 * v) / one;
            if (s == 0) begin
                res.red   = cv[hsv2rgb_pkg::CHAN_W-1:0];
                res.green = cv[hsv2rgb_pkg::CHAN_W-1:0];
                res.blue  = cv[hsv2rgb_pkg::CHAN_W-1:0];
                return res;
            end
            sector = h / span;
            rem    = h % span;
            cp = (255 * v * (one - s)) / (one * one);
            cq = (255 * v * (one * span - s * rem)) / (one * one * span);
            ct = (255 * v * (one * span - s * (span - rem))) / (one * one * span);
            case (sector[hsv2rgb_pkg::SECTOR_W-1:0])
                hsv2rgb_pkg::SEC_RED_YEL: res = {cv[7:0], ct[7:0], cp[7:0]};
                hsv2rgb_pkg::SEC_YEL_GRN: res = {cq[7:0], cv[7:0], cp[7:0]};
                hsv2rgb_pkg::SEC_GRN_CYN: res = {cp[7:0], cv[7:0], ct[7:0]};
                hsv2rgb_pkg::SEC_CYN_BLU: res = {cp[7:0], cq[7:0], cv[7:0]};
                hsv2rgb_pkg::SEC_BLU_MAG: res = {ct[7:0], cp[7:0], cv[7:0]};
                default:                  res = {cv[7:0], cp[7:0], cq[7:0]};
            endcase
            return res;
        endfunction

        function void note_input(t_hsv_pixel px);
            expected_rgb.push_back(convert_hsv(px));
        endfunction

        function void check_field(string name, logic [hsv2rgb_pkg::CHAN_W-1:0] exp_val,
                                  logic [hsv2rgb_pkg::CHAN_W-1:0] got_val);
            if (got_val !== exp_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, got_val);
                fail_count++;
            end
        endfunction

        function void check_output(t_rgb_pixel got);
            t_rgb_pixel exp_px;
            if (expected_rgb.size() == 0) begin
                $error("output word with none expected: r %0d g %0d b %0d",
                       got.red, got.green, got.blue);
                fail_count++;
                return;
            end
            exp_px = expected_rgb.pop_front();
            check_field("red", exp_px.red, got.red);
            check_field("green", exp_px.green, got.green);
            check_field("blue", exp_px.blue, got.blue);
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_valid;
    logic                                   o_stall;
    logic signed [hsv2rgb_pkg::HUE_W-1:0]   i_hue_angle;
    logic signed [hsv2rgb_pkg::LEVEL_W-1:0] i_saturation;
    logic signed [hsv2rgb_pkg::LEVEL_W-1:0] i_brightness;
    logic                                   o_valid;
    logic                                   i_stall;
    logic [hsv2rgb_pkg::CHAN_W-1:0]         o_red;
    logic [hsv2rgb_pkg::CHAN_W-1:0]         o_green;
    logic [hsv2rgb_pkg::CHAN_W-1:0]         o_blue;

    t_rgb_scoreboard sb = new();
    int              hold_off_reqs = 0;
    int              quiet_cycles  = 0;

    hsv_to_rgb_pixel_converter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue_angle  (i_hue_angle),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_input({i_hue_angle, i_saturation, i_brightness});
            end
            if (o_valid && !i_stall) begin
                sb.check_output({o_red, o_green, o_blue});
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // output side stall pattern with an occasional long hold
    initial begin
        int run_len;
        int stall_pct;
        int holds_done;
        holds_done = 0;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_reqs > holds_done) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else begin
                run_len = $urandom_range(8, 48);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 70;
                endcase
                repeat (run_len) begin
                    @(negedge i_clk);
                    i_stall <= ($urandom_range(0, 99) < stall_pct);
                end
            end
        end
    end

    task automatic send_word(t_hsv_pixel px);
        i_valid      <= 1'b1;
        i_hue_angle  <= px.hue;
        i_saturation <= px.sat;
        i_brightness <= px.bri;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [hsv2rgb_pkg::HUE_W-1:0] rand_hue();
        int k;
        case ($urandom_range(0, 3))
            0: return hsv2rgb_pkg::HUE_W'($urandom);
            1: return hsv2rgb_pkg::HUE_W'($urandom_range(0, 23039));
            2: begin
                k = $urandom_range(0, 6) * 3840 + $urandom_range(0, 4) - 2;
                return hsv2rgb_pkg::HUE_W'(k);
            end
            default: return hsv2rgb_pkg::HUE_W'(-$urandom_range(1, 131072));
        endcase
    endfunction

    function automatic logic signed [hsv2rgb_pkg::LEVEL_W-1:0] rand_level();
        case ($urandom_range(0, 9))
            0, 1: return hsv2rgb_pkg::LEVEL_W'($urandom);
            2:    return '0;
            3:    return hsv2rgb_pkg::LEVEL_W'($urandom_range(1023, 1025));
            default: return hsv2rgb_pkg::LEVEL_W'($urandom_range(0, 1024));
        endcase
    endfunction

    initial begin
        t_hsv_pixel directed[$];
        t_hsv_pixel px;
        int sent;
        int burst;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_hue_angle  = '0;
        i_saturation = '0;
        i_brightness = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes, every sector start, wrap and clamp cases, grey
        directed.push_back({18'sd0,       12'sd1024,  12'sd1024});
        directed.push_back({18'sd3840,    12'sd1024,  12'sd1024});
        directed.push_back({18'sd7680,    12'sd1024,  12'sd1024});
        directed.push_back({18'sd11520,   12'sd1024,  12'sd1024});
        directed.push_back({18'sd15360,   12'sd1024,  12'sd1024});
        directed.push_back({18'sd19200,   12'sd1024,  12'sd1024});
        directed.push_back({18'sd23039,   12'sd512,   12'sd1000});
        directed.push_back({18'sd23040,   12'sd700,   12'sd900});
        directed.push_back({-18'sd1,      12'sd1024,  12'sd1024});
        directed.push_back({-18'sd23040,  12'sd800,   12'sd600});
        directed.push_back({-18'sd131072, 12'sd1023,  12'sd1023});
        directed.push_back({18'sd131071,  12'sd1025,  12'sd1025});
        directed.push_back({18'sd5000,    12'sd0,     12'sd1024});
        directed.push_back({18'sd5000,    12'sd0,     12'sd777});
        directed.push_back({18'sd9000,    -12'sd2048, 12'sd1024});
        directed.push_back({18'sd9000,    12'sd2047,  12'sd2047});
        directed.push_back({18'sd13000,   12'sd600,   -12'sd2048});
        directed.push_back({18'sd17000,   12'sd600,   12'sd0});
        directed.push_back({18'sd21000,   12'sd1,     12'sd1});
        directed.push_back({18'sd1920,    12'sd1024,  12'sd2047});
        directed.push_back({18'sd3839,    12'sd1024,  12'sd1024});
        directed.push_back({-18'sd3841,   -12'sd1,    -12'sd1});
        foreach (directed[i]) begin
            send_word(directed[i]);
        end
        pause(3);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if (sent == 150 || sent == 600) begin
                    hold_off_reqs++;
                end
                px.hue = rand_hue();
                px.sat = rand_level();
                px.bri = rand_level();
                send_word(px);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                pause($urandom_range(1, 6));
            end
        end
        pause(1);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
